### rtl/core/csv_field_splitter_with_limits_assert.svh
// Assertion macros for the CSV value splitter RTL.
`ifndef CSV_FIELD_SPLITTER_WITH_LIMITS_ASSERT_SVH
`define CSV_FIELD_SPLITTER_WITH_LIMITS_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CSVFS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CSVFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/csvfs_pkg.sv
// Shared types and constants for the CSV value splitter.
`timescale 1ns / 1ps
package csvfs_pkg;

  localparam int ROW_BITS_DEF = 32;
  localparam int COL_BITS_DEF = 16;
  localparam int LEN_BITS_DEF = 16;

  localparam int RECENT_DEPTH = 3;
  localparam int CFG_IDX_W    = 2;

  localparam logic [7:0] DELIM_RESET = 8'd44;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_LF       = 8'h0a;

  // UTF-8 lead and continuation byte patterns
  localparam logic [7:0] UTF_MASK2   = 8'hc0;
  localparam logic [7:0] UTF_CONT    = 8'h80;
  localparam logic [7:0] UTF_MASK3   = 8'he0;
  localparam logic [7:0] UTF_LEAD2   = 8'hc0;
  localparam logic [7:0] UTF_LEAD3   = 8'he0;
  localparam logic [7:0] UTF_MASK4   = 8'hf8;
  localparam logic [7:0] UTF_LEAD4   = 8'hf0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DELIM     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_LIMIT = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_EOI  = 2'd2;

  // Placement codes
  localparam logic [1:0] PLACE_KEPT = 2'd0;
  localparam logic [1:0] PLACE_ROW  = 2'd1;
  localparam logic [1:0] PLACE_COL  = 2'd2;

  typedef enum logic [1:0] {
    PH_BEGIN,
    PH_UNQUOTED,
    PH_QUOTED,
    PH_AFTER
  } phase_t;

  typedef logic [RECENT_DEPTH-1:0][7:0] recent_t;

  // Work decoded for one byte or end-of-input mark
  typedef struct packed {
    logic emit;        // value end record
    logic empty_eoi;   // end of input with no value
    logic store;       // byte joins the value
    logic col_inc;
    logic row_inc;
    logic set_repair;
    logic eofq;
    logic fin;
    logic clear;
  } action_t;

endpackage

### rtl/core/csvfs_ifs.sv
// Valid/ready channel interfaces for input bytes, results and configuration.
`timescale 1ns / 1ps
interface csvfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface csvfs_out_if #(
  parameter int ROW_BITS = 32,
  parameter int COL_BITS = 16,
  parameter int LEN_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [7:0]          out_byte;
  logic [ROW_BITS-1:0] row_index;
  logic [COL_BITS-1:0] column_index;
  logic [LEN_BITS-1:0] kept_length;
  logic [1:0]          placement;
  logic                was_truncated;
  logic                was_repaired;
  logic                eof_in_quote;
  logic                final_value;

  modport source (
    output valid, output kind, output out_byte, output row_index,
    output column_index, output kept_length, output placement,
    output was_truncated, output was_repaired, output eof_in_quote,
    output final_value, input ready
  );
  modport sink (
    input valid, input kind, input out_byte, input row_index,
    input column_index, input kept_length, input placement,
    input was_truncated, input was_repaired, input eof_in_quote,
    input final_value, output ready
  );
endinterface

interface csvfs_cfg_if #(
  parameter int DATA_W = 32
);
  logic              valid;
  logic              ready;
  logic [1:0]        reg_index;
  logic [DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

### rtl/core/csvfs_utf8_trim.sv
// UTF-8 safe trim of a value's kept length at the byte limit.
`timescale 1ns / 1ps
module csvfs_utf8_trim import csvfs_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic [LEN_BITS-1:0] limit,
  input  recent_t             recent,
  output logic [LEN_BITS-1:0] kept_len
);

  logic lim_ge2;
  logic lim_ge3;

  assign lim_ge2 = limit >= LEN_BITS'(2);
  assign lim_ge3 = limit >= LEN_BITS'(3);

  // recent[0] is the newest stored byte; drop a partial sequence at the end
  always_comb begin
    priority if (limit == '0) begin
      kept_len = '0;
    end else if ((recent[0] & UTF_MASK2) == UTF_LEAD2) begin
      kept_len = limit - LEN_BITS'(1);
    end else if ((recent[0] & UTF_MASK2) != UTF_CONT) begin
      kept_len = limit;
    end else if (lim_ge2 && (recent[1] & UTF_MASK3) == UTF_LEAD2) begin
      kept_len = limit;
    end else if (lim_ge2 && (recent[1] & UTF_MASK3) == UTF_LEAD3) begin
      kept_len = limit - LEN_BITS'(2);
    end else if (lim_ge3 && (recent[2] & UTF_MASK4) == UTF_LEAD4) begin
      kept_len = limit - LEN_BITS'(3);
    end else begin
      kept_len = limit;
    end
  end

endmodule

### rtl/core/csv_field_splitter_with_limits.sv
// CSV value splitter with row, column and value-size limits (top level).
//
// Accepts one byte or end-of-input mark per cycle and sustains one item per
// clock while the result side keeps taking. An accepted item sits in the input
// register, is parsed there and lands in the result register; an item that
// causes no result moves on regardless of the result side. Throughput is set
// only by the result handshake: a stalled result blocks the input register.
// Configuration writes are taken every cycle and must only be made while the
// block is idle.
`timescale 1ns / 1ps
`include "csv_field_splitter_with_limits_assert.svh"
module csv_field_splitter_with_limits import csvfs_pkg::*; #(
  parameter int ROW_BITS = ROW_BITS_DEF,
  parameter int COL_BITS = COL_BITS_DEF,
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  csvfs_in_if.sink           in_ch,
  csvfs_out_if.source        out_ch,
  csvfs_cfg_if.sink          cfg_ch
);

  localparam int CFG_W0 = (ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS;
  localparam int CFG_W1 = (CFG_W0 > LEN_BITS) ? CFG_W0 : LEN_BITS;
  localparam int CFG_W  = (CFG_W1 > 8) ? CFG_W1 : 8;
  localparam int CNT_BITS = LEN_BITS + 1;

  // configuration registers
  logic [7:0]          delim_r;
  logic [ROW_BITS-1:0] row_lim_r;
  logic [COL_BITS-1:0] col_lim_r;
  logic [LEN_BITS-1:0] len_lim_r;
  logic [CFG_W-1:0]    cfg_data;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eoi_r;

  // parser state
  phase_t              phase_r, phase_nxt;
  logic [ROW_BITS-1:0] row_cnt_r;
  logic [COL_BITS-1:0] col_cnt_r;
  logic [CNT_BITS-1:0] val_cnt_r;
  recent_t             recent_r;
  logic                repair_r;

  // result register
  logic                out_valid_r;
  logic [1:0]          kind_r, kind_nxt;
  logic [7:0]          byte_r;
  logic [ROW_BITS-1:0] row_r;
  logic [COL_BITS-1:0] col_r;
  logic [LEN_BITS-1:0] len_r, len_nxt;
  logic [1:0]          place_r, place_nxt;
  logic                trunc_r, trunc_nxt;
  logic                repaired_r;
  logic                eofq_r;
  logic                fin_r;

  action_t             act;
  logic                is_delim, is_eol, is_quote;
  logic                store_out, produce, out_free, adv;
  logic [LEN_BITS-1:0] trim_len;

  // ---------------- configuration ----------------
  assign cfg_ch.ready = 1'b1;
  assign cfg_data     = CFG_W'(cfg_ch.wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r   <= DELIM_RESET;
      row_lim_r <= '1;
      col_lim_r <= '1;
      len_lim_r <= '1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_DELIM:     delim_r   <= cfg_data[7:0];
        REG_ROW_LIMIT: row_lim_r <= cfg_data[ROW_BITS-1:0];
        REG_COL_LIMIT: col_lim_r <= cfg_data[COL_BITS-1:0];
        REG_LEN_LIMIT: len_lim_r <= cfg_data[LEN_BITS-1:0];
        default:       delim_r   <= delim_r;
      endcase
    end
  end

  // ---------------- input register ----------------
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.in_byte;
      s1_eoi_r  <= in_ch.end_of_input;
    end
  end

  // ---------------- decode ----------------
  assign is_delim = s1_byte_r == delim_r;
  assign is_eol   = (s1_byte_r == CH_CR) || (s1_byte_r == CH_LF);
  assign is_quote = s1_byte_r == CH_QUOTE;

  // next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (s1_eoi_r) begin
      phase_nxt = PH_BEGIN;
    end else begin
      unique case (phase_r)
        PH_BEGIN: begin
          priority if (is_delim || is_eol) phase_nxt = PH_BEGIN;
          else if (is_quote)               phase_nxt = PH_QUOTED;
          else                             phase_nxt = PH_UNQUOTED;
        end
        PH_UNQUOTED: begin
          if (is_delim || is_eol) phase_nxt = PH_BEGIN;
        end
        PH_QUOTED: begin
          if (is_quote) phase_nxt = PH_AFTER;
        end
        PH_AFTER: begin
          priority if (is_delim) phase_nxt = PH_BEGIN;
          else if (is_quote)     phase_nxt = PH_QUOTED;
          else if (is_eol)       phase_nxt = PH_BEGIN;
          else                   phase_nxt = PH_UNQUOTED;
        end
        default: phase_nxt = PH_BEGIN;
      endcase
    end
  end

  // actions per phase; the delimiter test wins wherever it is made
  always_comb begin
    act = '0;
    if (s1_eoi_r) begin
      act.clear = 1'b1;
      act.fin   = 1'b1;
      unique case (phase_r)
        PH_BEGIN: begin
          if (col_cnt_r != '0) act.emit      = 1'b1;
          else                 act.empty_eoi = 1'b1;
        end
        PH_QUOTED: begin
          act.emit = 1'b1;
          act.eofq = 1'b1;
        end
        default: act.emit = 1'b1;
      endcase
      if (act.empty_eoi) act.fin = 1'b0;
    end else begin
      unique case (phase_r)
        PH_BEGIN: begin
          priority if (is_delim) begin
            act.emit    = 1'b1;
            act.col_inc = 1'b1;
          end else if (is_eol) begin
            // skip empty lines
            if (col_cnt_r != '0) begin
              act.emit    = 1'b1;
              act.row_inc = 1'b1;
            end
          end else if (is_quote) begin
            act.store = 1'b0;
          end else begin
            act.store = 1'b1;
          end
        end
        PH_UNQUOTED: begin
          priority if (is_delim) begin
            act.emit    = 1'b1;
            act.col_inc = 1'b1;
          end else if (is_eol) begin
            act.emit    = 1'b1;
            act.row_inc = 1'b1;
          end else begin
            act.store = 1'b1;
          end
        end
        PH_QUOTED: begin
          act.store = !is_quote;
        end
        PH_AFTER: begin
          priority if (is_delim) begin
            act.emit    = 1'b1;
            act.col_inc = 1'b1;
          end else if (is_quote) begin
            act.store = 1'b1;
          end else if (is_eol) begin
            act.emit    = 1'b1;
            act.row_inc = 1'b1;
          end else begin
            act.set_repair = 1'b1;
            act.store      = 1'b1;
          end
        end
        default: act = '0;
      endcase
    end
  end

  assign store_out = act.store && (val_cnt_r < {1'b0, len_lim_r});
  assign produce   = act.emit || act.empty_eoi || store_out;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign adv       = s1_valid_r && (!produce || out_free);

  // ---------------- value end record ----------------
  csvfs_utf8_trim #(
    .LEN_BITS(LEN_BITS)
  ) u_trim (
    .limit   (len_lim_r),
    .recent  (recent_r),
    .kept_len(trim_len)
  );

  always_comb begin
    place_nxt = PLACE_KEPT;
    trunc_nxt = 1'b0;
    len_nxt   = '0;
    kind_nxt  = KIND_BYTE;
    if (act.emit) begin
      kind_nxt = KIND_END;
      priority if (row_cnt_r >= row_lim_r) begin
        place_nxt = PLACE_ROW;
      end else if (col_cnt_r >= col_lim_r) begin
        place_nxt = PLACE_COL;
      end else if (val_cnt_r > {1'b0, len_lim_r}) begin
        trunc_nxt = 1'b1;
        len_nxt   = trim_len;
      end else begin
        len_nxt = val_cnt_r[LEN_BITS-1:0];
      end
    end else if (act.empty_eoi) begin
      kind_nxt = KIND_EOI;
    end
  end

  // ---------------- parser state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_BEGIN;
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      val_cnt_r <= '0;
      recent_r  <= '0;
      repair_r  <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      if (act.clear) begin
        row_cnt_r <= '0;
        col_cnt_r <= '0;
        val_cnt_r <= '0;
        recent_r  <= '0;
        repair_r  <= 1'b0;
      end else begin
        if (act.row_inc) begin
          if (!(&row_cnt_r)) row_cnt_r <= row_cnt_r + ROW_BITS'(1);
          col_cnt_r <= '0;
        end else if (act.col_inc && !(&col_cnt_r)) begin
          col_cnt_r <= col_cnt_r + COL_BITS'(1);
        end
        if (act.emit) begin
          val_cnt_r <= '0;
          repair_r  <= 1'b0;
        end else begin
          if (act.store && !(&val_cnt_r)) val_cnt_r <= val_cnt_r + CNT_BITS'(1);
          if (act.set_repair) repair_r <= 1'b1;
        end
        // keep the newest three stored bytes for the UTF-8 trim
        if (store_out) recent_r <= {recent_r[RECENT_DEPTH-2:0], s1_byte_r};
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && produce) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && produce) begin
      kind_r     <= kind_nxt;
      byte_r     <= store_out && !act.emit ? s1_byte_r : 8'd0;
      row_r      <= act.empty_eoi ? '0 : row_cnt_r;
      col_r      <= act.empty_eoi ? '0 : col_cnt_r;
      len_r      <= len_nxt;
      place_r    <= place_nxt;
      trunc_r    <= trunc_nxt;
      repaired_r <= act.emit && repair_r;
      eofq_r     <= act.emit && act.eofq;
      fin_r      <= act.emit && act.fin;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.out_byte      = byte_r;
  assign out_ch.row_index     = row_r;
  assign out_ch.column_index  = col_r;
  assign out_ch.kept_length   = len_r;
  assign out_ch.placement     = place_r;
  assign out_ch.was_truncated = trunc_r;
  assign out_ch.was_repaired  = repaired_r;
  assign out_ch.eof_in_quote  = eofq_r;
  assign out_ch.final_value   = fin_r;

  // ---------------- assertions ----------------
  `CSVFS_ASSERT_SAME(a_begin_empty, clk, rst_n, phase_r == PH_BEGIN, (val_cnt_r == '0) && !repair_r, "value state left over at value begin")
  `CSVFS_ASSERT_NEXT(a_eoi_clears, clk, rst_n, adv && s1_eoi_r, (phase_r == PH_BEGIN) && (row_cnt_r == '0) && (col_cnt_r == '0), "end of input did not clear parser")
  `CSVFS_ASSERT_SAME(a_trunc_kept, clk, rst_n, out_valid_r && trunc_r, (place_r == PLACE_KEPT) && (kind_r == KIND_END), "truncation flagged on a skipped value or non-record")

endmodule
